FILE: rtl/core/crc_framed_byte_deframer_macros.svh
// Assertion macros for the sync/length/CRC byte deframer.
`ifndef CRC_FRAMED_BYTE_DEFRAMER_MACROS_SVH
`define CRC_FRAMED_BYTE_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CFBD_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfbd: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CFBD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfbd: next-cycle check failed");

`endif

FILE: rtl/core/cfbd_pkg.sv
// Shared types, codes and the CRC byte update for the byte deframer.
`default_nettype none

package cfbd_pkg;

   localparam int unsigned CFBD_MAX_PAYLOAD = 512;

   localparam logic [7:0]  SYNC_FIRST = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND = 8'h55;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP_BIT = 16'h8000;
   localparam logic [9:0]  IDX_MAX = 10'd1023;

   localparam logic       KIND_PAYLOAD = 1'b0;
   localparam logic       KIND_VERDICT = 1'b1;

   localparam logic [1:0] STAT_GOOD = 2'd0;
   localparam logic [1:0] STAT_MISMATCH = 2'd1;
   localparam logic [1:0] STAT_OVERSIZE = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT_A  = 3'd0,
      PH_HUNT_B  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CRC_LO  = 3'd5,
      PH_CRC_HI  = 3'd6
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [9:0] byte_index;
      logic [1:0] status;
   } rsp_type;

   // CRC-16-CCITT, MSB first, one byte
   function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                   input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP_BIT) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [9:0] sat_index(input logic [15:0] v);
      return (v > {6'd0, IDX_MAX}) ? IDX_MAX : v[9:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/crc_framed_byte_deframer.sv
// Sync/length/CRC byte deframer, top level.
//
// Usage:
//   req_*  : one received link byte per transfer (valid/ready).
//   rsp_*  : payload bytes with their index (kind 0), passed on cut-through,
//            and one end-of-frame verdict (kind 1) per frame: good CRC,
//            CRC mismatch, or oversize length (reported as soon as the
//            length is complete; hunting for 0xAA 0x55 then resumes).
//   A byte that yields nothing (sync, length, CRC low byte) is absorbed.
// Timing:
//   A byte sits in an input register, goes combinationally through the parser
//   and the byte-wide CRC update, and lands in the result register, from
//   which its result is offered. One byte per cycle is taken sustained while
//   no result waits on rsp_ready; the combinational CRC byte update is the
//   longest path.
// Reset: synchronous, active high; clears both valid flags and sends the
//   parser back to hunting for the first sync byte.
// Stall: while a result waits on rsp_ready the input register holds its
//   byte; req_ready stays high only while the input register is empty.
`default_nettype none

`include "crc_framed_byte_deframer_macros.svh"

module crc_framed_byte_deframer
   import cfbd_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = CFBD_MAX_PAYLOAD
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_kind,
   output logic [7:0]      rsp_data,
   output logic [9:0]      rsp_byte_index,
   output logic [1:0]      rsp_status
);

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_vld_ff;
   rsp_type    rsp_ff;
   logic       adv;
   logic       res_vld;
   rsp_type    res;

   // input byte moves through the parser when the result slot is free or is being read out
   assign adv       = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   cfbd_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (adv),
      .rx_byte (in_byte_ff),
      .res_vld (res_vld),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= res_vld;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res_vld) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_data       = rsp_ff.data;
   assign rsp_byte_index = rsp_ff.byte_index;
   assign rsp_status     = rsp_ff.status;

   `CFBD_ASSERT_IMPL(a_verdict_data_zero, clock, reset, rsp_vld_ff && (rsp_ff.kind == KIND_VERDICT), rsp_ff.data == 8'd0)
   `CFBD_ASSERT_IMPL(a_payload_status_good, clock, reset, rsp_vld_ff && (rsp_ff.kind == KIND_PAYLOAD), rsp_ff.status == STAT_GOOD)
   `CFBD_ASSERT_NEXT(a_in_hold_on_stall, clock, reset, in_vld_ff && !adv, in_vld_ff && $stable(in_byte_ff))

endmodule

`default_nettype wire

FILE: rtl/core/cfbd_parser.sv
// Frame parser: sync hunt, length, cut-through payload, CRC check and verdict.
`default_nettype none

module cfbd_parser
   import cfbd_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = CFBD_MAX_PAYLOAD
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic [7:0] rx_byte,
   output logic            res_vld,
   output rsp_type         res
);

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

   phase_type         phase_ff, phase_in;
   logic [15:0]       frame_length_ff, frame_length_in;
   logic [CNT_W-1:0]  bytes_seen_ff, bytes_seen_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        crc_lo_ff, crc_lo_in;
   logic [CNT_W:0]    count_next;
   logic [15:0]       len_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT_A;
         frame_length_ff <= 16'd0;
         bytes_seen_ff   <= '0;
         crc_ff          <= CRC_INIT;
         crc_lo_ff       <= 8'd0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         bytes_seen_ff   <= bytes_seen_in;
         crc_ff          <= crc_in;
         crc_lo_ff       <= crc_lo_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      bytes_seen_in   = bytes_seen_ff;
      crc_in          = crc_ff;
      crc_lo_in       = crc_lo_ff;
      res_vld         = 1'b0;
      res.kind        = KIND_PAYLOAD;
      res.data        = 8'd0;
      res.byte_index  = 10'd0;
      res.status      = STAT_GOOD;
      count_next      = {1'b0, bytes_seen_ff} + {{CNT_W{1'b0}}, 1'b1};
      len_full        = {rx_byte, frame_length_ff[7:0]};

      case (phase_ff)
         PH_HUNT_B: begin
            if (rx_byte == SYNC_SECOND) begin
               phase_in = PH_LEN_LO;
            end else if (rx_byte != SYNC_FIRST) begin
               phase_in = PH_HUNT_A;
            end
         end
         PH_LEN_LO: begin
            frame_length_in = {8'd0, rx_byte};
            phase_in        = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            frame_length_in = len_full;
            bytes_seen_in   = '0;
            crc_in          = CRC_INIT;
            if ({1'b0, len_full} > 17'(MAX_PAYLOAD)) begin
               res_vld        = 1'b1;
               res.kind       = KIND_VERDICT;
               res.byte_index = sat_index(len_full);
               res.status     = STAT_OVERSIZE;
               phase_in       = PH_HUNT_A;
            end else if (len_full == 16'd0) begin
               phase_in = PH_CRC_LO;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            crc_in         = crc_byte_update(crc_ff, rx_byte);
            res_vld        = 1'b1;
            res.data       = rx_byte;
            res.byte_index = sat_index(16'(bytes_seen_ff));
            bytes_seen_in  = count_next[CNT_W-1:0];
            if (17'(count_next) >= {1'b0, frame_length_ff}) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            crc_lo_in = rx_byte;
            phase_in  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            res_vld        = 1'b1;
            res.kind       = KIND_VERDICT;
            res.byte_index = sat_index(frame_length_ff);
            res.status     = ({rx_byte, crc_lo_ff} == crc_ff) ? STAT_GOOD : STAT_MISMATCH;
            crc_in         = CRC_INIT;
            phase_in       = PH_HUNT_A;
         end
         default: begin
            // hunting for the first sync byte; unused codes land here too
            phase_in = (rx_byte == SYNC_FIRST) ? PH_HUNT_B : PH_HUNT_A;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: bench/crc_framed_byte_deframer_tb.sv
// Testbench for the byte deframer: directed frames, then random frames checked by a predictor.
`default_nettype none

module crc_framed_byte_deframer_tb;
   import cfbd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_LEN = CFBD_MAX_PAYLOAD;
   localparam int RANDOM_BYTES = 2000;
   localparam int IDLE_LIMIT = 2000;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       typed;
      rsp_type    result;
   } stim_row;

   localparam rsp_type NONE = '0;

   // typed results only where obvious; the rest come from the predictor
   localparam stim_row DIRECTED [26] = '{
      '{8'h00,       1'b0, NONE},
      '{SYNC_FIRST,  1'b0, NONE},
      '{SYNC_FIRST,  1'b0, NONE},   // repeated first sync byte still syncs
      '{SYNC_SECOND, 1'b0, NONE},
      '{8'h00,       1'b0, NONE},
      '{8'h00,       1'b0, NONE},   // zero length: CRC follows at once
      '{8'hFF,       1'b0, NONE},
      '{8'hFF,       1'b1, '{KIND_VERDICT, 8'h00, 10'd0, STAT_GOOD}},
      '{SYNC_FIRST,  1'b0, NONE},
      '{8'h12,       1'b0, NONE},   // broken sync
      '{SYNC_FIRST,  1'b0, NONE},
      '{SYNC_SECOND, 1'b0, NONE},
      '{8'hFF,       1'b0, NONE},
      '{8'hFF,       1'b1, '{KIND_VERDICT, 8'h00, IDX_MAX, STAT_OVERSIZE}},
      '{SYNC_FIRST,  1'b0, NONE},
      '{SYNC_SECOND, 1'b0, NONE},
      '{8'h01,       1'b0, NONE},
      '{8'h02,       1'b1, '{KIND_VERDICT, 8'h00, 10'd513, STAT_OVERSIZE}},
      '{SYNC_FIRST,  1'b0, NONE},
      '{SYNC_SECOND, 1'b0, NONE},
      '{8'h02,       1'b0, NONE},
      '{8'h00,       1'b0, NONE},
      '{SYNC_FIRST,  1'b1, '{KIND_PAYLOAD, SYNC_FIRST, 10'd0, STAT_GOOD}},
      '{SYNC_SECOND, 1'b1, '{KIND_PAYLOAD, SYNC_SECOND, 10'd1, STAT_GOOD}},
      '{8'h00,       1'b0, NONE},
      '{8'h00,       1'b0, NONE}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_data;
   logic [9:0] rsp_byte_index;
   logic [1:0] rsp_status;

   crc_framed_byte_deframer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_data       (rsp_data),
      .rsp_byte_index (rsp_byte_index),
      .rsp_status     (rsp_status)
   );

   always #2 clock = ~clock;

   rsp_type pending_deliveries [$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;
   int      bytes_sent = 0;
   bit      sender_calm = 1'b0;
   bit      receiver_calm = 1'b0;
   logic    row_typed = 1'b0;
   rsp_type row_result = '0;

   // deframer state as seen by the predictor
   phase_type   parse_phase = PH_HUNT_A;
   logic [15:0] frame_len = '0;
   logic [15:0] payload_seen = '0;
   logic [15:0] crc_run = CRC_INIT;
   logic [7:0]  crc_first = '0;

   // CCITT, one input bit at a time into the feedback
   function automatic logic [15:0] ccitt_step(input logic [15:0] acc, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = acc[15] ^ b[i];
         acc = {acc[14:0], 1'b0};
         if (fb) acc = acc ^ CRC_POLY;
      end
      return acc;
   endfunction

   function automatic logic [9:0] clamp_index(input logic [15:0] v);
      return (v > 16'd1023) ? IDX_MAX : v[9:0];
   endfunction

   function automatic bit deframe_byte(input logic [7:0] b, output rsp_type res);
      logic [15:0] got_crc;
      bit          made;
      res = '0;
      made = 1'b0;
      case (parse_phase)
         PH_HUNT_B: begin
            if (b == SYNC_SECOND) parse_phase = PH_LEN_LO;
            else if (b != SYNC_FIRST) parse_phase = PH_HUNT_A;
         end
         PH_LEN_LO: begin
            frame_len = {8'h00, b};
            parse_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            frame_len[15:8] = b;
            payload_seen = '0;
            crc_run = CRC_INIT;
            if (frame_len > MAX_LEN) begin
               res = '{KIND_VERDICT, 8'h00, clamp_index(frame_len), STAT_OVERSIZE};
               made = 1'b1;
               parse_phase = PH_HUNT_A;
            end else begin
               parse_phase = (frame_len == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            crc_run = ccitt_step(crc_run, b);
            res = '{KIND_PAYLOAD, b, clamp_index(payload_seen), STAT_GOOD};
            made = 1'b1;
            payload_seen = payload_seen + 16'd1;
            if (payload_seen >= frame_len) parse_phase = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            crc_first = b;
            parse_phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            got_crc = {b, crc_first};
            res = '{KIND_VERDICT, 8'h00, clamp_index(frame_len),
                    (got_crc == crc_run) ? STAT_GOOD : STAT_MISMATCH};
            made = 1'b1;
            parse_phase = PH_HUNT_A;
            crc_run = CRC_INIT;
         end
         default: begin
            parse_phase = (b == SYNC_FIRST) ? PH_HUNT_B : PH_HUNT_A;
         end
      endcase
      return made;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
      end
   endtask

   always @(posedge clock) begin : deframer_monitor
      rsp_type predicted;
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (deframe_byte(req_rx_byte, predicted)) begin
               pending_deliveries.push_back(row_typed ? row_result : predicted);
            end
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_deliveries.size() == 0) begin
               report_mismatch("unexpected result", 16'({rsp_kind, rsp_byte_index}),
                               16'h0000);
            end else begin
               want = pending_deliveries.pop_front();
               if (rsp_kind !== want.kind) begin
                  report_mismatch("kind", 16'(rsp_kind), 16'(want.kind));
               end
               if (rsp_data !== want.data) begin
                  report_mismatch("data", 16'(rsp_data), 16'(want.data));
               end
               if (rsp_byte_index !== want.byte_index) begin
                  report_mismatch("byte_index", 16'(rsp_byte_index), 16'(want.byte_index));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 16'(rsp_status), 16'(want.status));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // result side: random stall before each transfer, calm stretches now and then
   initial begin : result_sink
      int stall;
      forever begin
         if ($urandom_range(0, 15) == 0) receiver_calm = !receiver_calm;
         stall = receiver_calm ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic present_byte(input logic [7:0] b, input logic typed = 1'b0,
                               input rsp_type result = '0);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      row_typed = typed;
      row_result = result;
      do @(posedge clock); while (req_ready !== 1'b1);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic settle_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_deliveries.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_frame();
      logic [15:0] len;
      logic [15:0] crc_val;
      logic [7:0]  b;
      int          pick;
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom);
            if (b == SYNC_FIRST) b = 8'h00;
            present_byte(b);
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         present_byte(SYNC_FIRST);
         b = 8'($urandom);
         if (b == SYNC_FIRST || b == SYNC_SECOND) b = 8'h5A;
         present_byte(b);
      end
      present_byte(SYNC_FIRST);
      if ($urandom_range(0, 9) == 0) present_byte(SYNC_FIRST);
      present_byte(SYNC_SECOND);

      pick = $urandom_range(0, 199);
      if (pick < 3) len = 16'(MAX_LEN);
      else if (pick < 6) len = 16'(MAX_LEN + 1);
      else if (pick < 9) len = 16'hFFFF;
      else if (pick < 20) len = 16'($urandom_range(MAX_LEN + 2, 65534));
      else if (pick < 36) len = 16'h0000;
      else len = 16'($urandom_range(1, 16));
      present_byte(len[7:0]);
      present_byte(len[15:8]);
      if (len > MAX_LEN) return;

      crc_val = CRC_INIT;
      for (int i = 0; i < int'(len); i++) begin
         pick = $urandom_range(0, 15);
         case (pick)
            0: b = 8'h00;
            1: b = 8'hFF;
            2: b = SYNC_FIRST;
            3: b = SYNC_SECOND;
            default: b = 8'($urandom);
         endcase
         crc_val = ccitt_step(crc_val, b);
         present_byte(b);
      end
      if ($urandom_range(0, 6) == 0) begin
         if ($urandom_range(0, 1) == 1) crc_val = crc_val ^ (16'h0001 << $urandom_range(0, 15));
         else crc_val = 16'($urandom);
      end
      present_byte(crc_val[7:0]);
      present_byte(crc_val[15:8]);
   endtask

   initial begin : stimulus
      int frames;
      frames = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIRECTED); r++) begin
         present_byte(DIRECTED[r].rx_byte, DIRECTED[r].typed, DIRECTED[r].result);
      end

      while (bytes_sent < RANDOM_BYTES + $size(DIRECTED)) begin
         if ($urandom_range(0, 7) == 0) sender_calm = !sender_calm;
         send_random_frame();
         frames++;
         if (frames == 30) settle_results();
      end

      settle_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
